// File: rtl/i2c_register_access_master_top_assert.svh
// Assertion macros for the I2C register access master
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_ASSERT_SVH

// Implication in the same cycle, sampled on clock, off during reset
`define I2CRAM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle
`define I2CRAM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/i2cram_pkg.sv
// Package with phase codes, command codes and queue entry type for the I2C master
package i2cram_pkg;

   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_START_A = 5'd1;
   localparam logic [4:0] PH_START_B = 5'd2;
   localparam logic [4:0] PH_START_C = 5'd3;
   localparam logic [4:0] PH_WB_SET  = 5'd4;
   localparam logic [4:0] PH_WB_HI   = 5'd5;
   localparam logic [4:0] PH_WB_LO   = 5'd6;
   localparam logic [4:0] PH_WA_REL  = 5'd7;
   localparam logic [4:0] PH_WA_HI   = 5'd8;
   localparam logic [4:0] PH_WA_LO   = 5'd9;
   localparam logic [4:0] PH_RD_REL  = 5'd10;
   localparam logic [4:0] PH_RB_HI   = 5'd11;
   localparam logic [4:0] PH_RB_SMP  = 5'd12;
   localparam logic [4:0] PH_RB_LO   = 5'd13;
   localparam logic [4:0] PH_NK_HI   = 5'd14;
   localparam logic [4:0] PH_NK_LO   = 5'd15;
   localparam logic [4:0] PH_STOP_A  = 5'd16;
   localparam logic [4:0] PH_STOP_B  = 5'd17;
   localparam logic [4:0] PH_STOP_C  = 5'd18;

   localparam logic [1:0] KIND_PROBE = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   localparam logic OP_CMD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Class given to each transaction by the front
   localparam logic [1:0] CLS_NONE = 2'd0;
   localparam logic [1:0] CLS_CMD  = 2'd1;
   localparam logic [1:0] CLS_TICK = 2'd2;

   localparam logic [2:0] STEP_ADDR = 3'd0;
   localparam logic [2:0] STEP_REG  = 3'd1;
   localparam logic [2:0] STEP_DATA = 3'd2;

   localparam logic [6:0] DEV_ADDR_RESET = 7'd118;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [QUEUE_PTR_W-1:0] qptr_type;
   typedef logic [QUEUE_CNT_W-1:0] qcnt_type;

   localparam qptr_type QUEUE_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam qcnt_type QUEUE_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0] cls;
      logic [1:0] kind;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      logic       sda_in;
   } item_type;

endpackage

// File: rtl/i2c_register_access_master_top.sv
// Top level of the I2C register access master
//
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_stall  | op, kind, reg_addr, wr_data, sda_in
//   rsp_    | out       | rsp_valid / rsp_stall  | scl, sda, sda_enable, busy, done, ack, rd_data
//   csr_    | in        | csr_valid / csr_ready  | device_address
//
// One transaction per cycle sustained while req_stall and rsp_stall are low; an accepted
// transaction waits in the front queue, then goes through the result register, before
// its result is offered on rsp_.
// The sequencer computes its next phase combinationally, registered on each pop; this sets that rate.
// Reset is synchronous: phase goes idle, queue empties, device address returns to 118.
// rsp_stall holds the result register; the two-entry queue stalls req_ only once full.
module i2c_register_access_master_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_wr_data,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_sda_enable,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic       rsp_ack_ok,
   output logic [7:0] rsp_rd_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_device_address
);

   `include "i2c_register_access_master_top_assert.svh"

   logic [6:0]           dev_addr_reg_ff, dev_addr_reg_in;
   logic                 q_valid;
   logic                 q_pop;
   i2cram_pkg::item_type q_item;

   assign csr_ready          = 1'b1;
   assign dev_addr_reg_in    = (csr_valid && csr_ready) ? csr_device_address : dev_addr_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_reg_ff <= i2cram_pkg::DEV_ADDR_RESET;
      end else begin
         dev_addr_reg_ff <= dev_addr_reg_in;
      end
   end

   i2cram_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_kind     (req_kind),
      .req_reg_addr (req_reg_addr),
      .req_wr_data  (req_wr_data),
      .req_sda_in   (req_sda_in),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop)
   );

   i2cram_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .dev_addr       (dev_addr_reg_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_sda_enable (rsp_sda_enable),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_ack_ok     (rsp_ack_ok),
      .rsp_rd_data    (rsp_rd_data)
   );

   `I2CRAM_ASSERT_NOW(a_done_not_busy, rsp_valid && rsp_done_res, !rsp_busy_res && rsp_scl_level && rsp_sda_level, "done reported with bus not idle")
   `I2CRAM_ASSERT_NOW(a_release_high, rsp_valid && !rsp_sda_enable, rsp_sda_level && rsp_busy_res, "released SDA not high or not busy")
   `I2CRAM_ASSERT_NOW(a_idle_levels, rsp_valid && !rsp_busy_res, rsp_scl_level && rsp_sda_level && rsp_sda_enable, "idle bus levels wrong")
   `I2CRAM_ASSERT_NEXT(a_pop_fills, q_pop, rsp_valid, "popped transaction missing at result stage")

endmodule

// File: rtl/i2cram_front.sv
// Front end: classifies incoming transactions and buffers them in a two-entry queue
module i2cram_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_op,
   input  logic [1:0]           req_kind,
   input  logic [7:0]           req_reg_addr,
   input  logic [7:0]           req_wr_data,
   input  logic                 req_sda_in,
   output logic                 q_valid,
   output i2cram_pkg::item_type q_item,
   input  logic                 q_pop
);

   i2cram_pkg::item_type q_ff [i2cram_pkg::QUEUE_DEPTH];
   i2cram_pkg::item_type new_item;
   i2cram_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   i2cram_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   i2cram_pkg::qcnt_type count_ff, count_in;
   logic                 push;

   always_comb begin
      new_item.kind     = req_kind;
      new_item.reg_addr = req_reg_addr;
      new_item.wr_data  = req_wr_data;
      new_item.sda_in   = req_sda_in;
      priority if (req_op == i2cram_pkg::OP_TICK) begin
         new_item.cls = i2cram_pkg::CLS_TICK;
      end else if (req_kind == i2cram_pkg::KIND_NONE) begin
         new_item.cls = i2cram_pkg::CLS_NONE;
      end else begin
         new_item.cls = i2cram_pkg::CLS_CMD;
      end
   end

   assign req_stall = (count_ff == i2cram_pkg::QUEUE_FULL);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == i2cram_pkg::QUEUE_LAST) ? '0
                                                          : wr_ptr_ff + i2cram_pkg::qptr_type'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == i2cram_pkg::QUEUE_LAST) ? '0
                                                          : rd_ptr_ff + i2cram_pkg::qptr_type'(1);
      end
      count_in = count_ff + i2cram_pkg::qcnt_type'(push) - i2cram_pkg::qcnt_type'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: rtl/i2cram_back.sv
// Back end: bus phase sequencer and registered result stage
module i2cram_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  i2cram_pkg::item_type q_item,
   output logic                 q_pop,
   input  logic [6:0]           dev_addr,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_scl_level,
   output logic                 rsp_sda_level,
   output logic                 rsp_sda_enable,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic                 rsp_ack_ok,
   output logic [7:0]           rsp_rd_data
);

   logic [4:0] phase_ff, phase_in, ph;
   logic [3:0] bit_index_ff, bit_index_in, bit_inc;
   logic [7:0] tx_shift_ff, tx_shift_in;
   logic [2:0] byte_step_ff, byte_step_in;
   logic [1:0] txn_kind_ff, txn_kind_in;
   logic [7:0] reg_latch_ff, reg_latch_in;
   logic [7:0] data_latch_ff, data_latch_in;
   logic       ack_flag_ff, ack_flag_in;
   logic [7:0] rx_byte_ff, rx_byte_in;
   logic       done;
   logic       scl, sdal, en;

   logic       valid_ff;
   logic       scl_ff, sdal_ff, en_ff, busy_ff, done_ff, ack_ff;
   logic [7:0] rd_ff;

   // Take the next transaction whenever the result stage is empty or draining
   assign q_pop   = q_valid && (!valid_ff || !rsp_stall);
   assign bit_inc = bit_index_ff + 4'd1;

   always_comb begin
      ph            = (phase_ff > i2cram_pkg::PH_STOP_C) ? i2cram_pkg::PH_IDLE : phase_ff;
      phase_in      = ph;
      bit_index_in  = bit_index_ff;
      tx_shift_in   = tx_shift_ff;
      byte_step_in  = byte_step_ff;
      txn_kind_in   = txn_kind_ff;
      reg_latch_in  = reg_latch_ff;
      data_latch_in = data_latch_ff;
      ack_flag_in   = ack_flag_ff;
      rx_byte_in    = rx_byte_ff;
      done          = 1'b0;

      unique case (q_item.cls)
         i2cram_pkg::CLS_CMD: begin
            if (ph == i2cram_pkg::PH_IDLE) begin
               txn_kind_in   = q_item.kind;
               reg_latch_in  = q_item.reg_addr;
               data_latch_in = q_item.wr_data;
               ack_flag_in   = 1'b1;
               tx_shift_in   = {dev_addr, 1'b0};
               bit_index_in  = 4'd0;
               byte_step_in  = i2cram_pkg::STEP_ADDR;
               phase_in      = i2cram_pkg::PH_START_A;
            end
         end
         i2cram_pkg::CLS_TICK: begin
            if (ph != i2cram_pkg::PH_IDLE) begin
               unique case (ph)
                  i2cram_pkg::PH_START_A: phase_in = i2cram_pkg::PH_START_B;
                  i2cram_pkg::PH_START_B: phase_in = i2cram_pkg::PH_START_C;
                  i2cram_pkg::PH_START_C: phase_in = i2cram_pkg::PH_WB_SET;
                  i2cram_pkg::PH_WB_SET:  phase_in = i2cram_pkg::PH_WB_HI;
                  i2cram_pkg::PH_WB_HI:   phase_in = i2cram_pkg::PH_WB_LO;
                  i2cram_pkg::PH_WB_LO: begin
                     tx_shift_in  = {tx_shift_ff[6:0], 1'b0};
                     bit_index_in = bit_inc;
                     phase_in     = bit_inc[3] ? i2cram_pkg::PH_WA_REL
                                               : i2cram_pkg::PH_WB_SET;
                  end
                  i2cram_pkg::PH_WA_REL:  phase_in = i2cram_pkg::PH_WA_HI;
                  i2cram_pkg::PH_WA_HI: begin
                     // read address ACK is clocked but not checked
                     if (q_item.sda_in && !(txn_kind_ff == i2cram_pkg::KIND_READ &&
                                            byte_step_ff == i2cram_pkg::STEP_DATA)) begin
                        ack_flag_in = 1'b0;
                     end
                     phase_in = i2cram_pkg::PH_WA_LO;
                  end
                  i2cram_pkg::PH_WA_LO: begin
                     priority if (!ack_flag_ff || txn_kind_ff == i2cram_pkg::KIND_PROBE) begin
                        phase_in = i2cram_pkg::PH_STOP_A;
                     end else if (byte_step_ff == i2cram_pkg::STEP_ADDR) begin
                        tx_shift_in  = reg_latch_ff;
                        bit_index_in = 4'd0;
                        byte_step_in = i2cram_pkg::STEP_REG;
                        phase_in     = i2cram_pkg::PH_WB_SET;
                     end else if (byte_step_ff == i2cram_pkg::STEP_REG) begin
                        bit_index_in = 4'd0;
                        byte_step_in = i2cram_pkg::STEP_DATA;
                        if (txn_kind_ff == i2cram_pkg::KIND_WRITE) begin
                           tx_shift_in = data_latch_ff;
                           phase_in    = i2cram_pkg::PH_WB_SET;
                        end else begin
                           // repeated start, then address with read bit
                           tx_shift_in = {dev_addr, 1'b1};
                           phase_in    = i2cram_pkg::PH_START_A;
                        end
                     end else if (txn_kind_ff == i2cram_pkg::KIND_READ) begin
                        rx_byte_in   = 8'd0;
                        bit_index_in = 4'd0;
                        phase_in     = i2cram_pkg::PH_RD_REL;
                     end else begin
                        phase_in = i2cram_pkg::PH_STOP_A;
                     end
                  end
                  i2cram_pkg::PH_RD_REL:  phase_in = i2cram_pkg::PH_RB_HI;
                  i2cram_pkg::PH_RB_HI: begin
                     rx_byte_in = {rx_byte_ff[6:0], q_item.sda_in};
                     phase_in   = i2cram_pkg::PH_RB_SMP;
                  end
                  i2cram_pkg::PH_RB_SMP:  phase_in = i2cram_pkg::PH_RB_LO;
                  i2cram_pkg::PH_RB_LO: begin
                     bit_index_in = bit_inc;
                     phase_in     = bit_inc[3] ? i2cram_pkg::PH_NK_HI
                                               : i2cram_pkg::PH_RB_HI;
                  end
                  i2cram_pkg::PH_NK_HI:   phase_in = i2cram_pkg::PH_NK_LO;
                  i2cram_pkg::PH_NK_LO:   phase_in = i2cram_pkg::PH_STOP_A;
                  i2cram_pkg::PH_STOP_A:  phase_in = i2cram_pkg::PH_STOP_B;
                  i2cram_pkg::PH_STOP_B:  phase_in = i2cram_pkg::PH_STOP_C;
                  i2cram_pkg::PH_STOP_C: begin
                     phase_in = i2cram_pkg::PH_IDLE;
                     done     = 1'b1;
                  end
                  default:                phase_in = i2cram_pkg::PH_IDLE;
               endcase
            end
         end
         default: ;
      endcase
   end

   // Pin levels follow the phase after this transaction
   always_comb begin
      scl = (phase_in == i2cram_pkg::PH_IDLE)    || (phase_in == i2cram_pkg::PH_START_A) ||
            (phase_in == i2cram_pkg::PH_START_B) || (phase_in == i2cram_pkg::PH_WB_HI)   ||
            (phase_in == i2cram_pkg::PH_WA_HI)   || (phase_in == i2cram_pkg::PH_RB_HI)   ||
            (phase_in == i2cram_pkg::PH_RB_SMP)  || (phase_in == i2cram_pkg::PH_NK_HI)   ||
            (phase_in == i2cram_pkg::PH_STOP_B)  || (phase_in == i2cram_pkg::PH_STOP_C);
      en  = !((phase_in >= i2cram_pkg::PH_WA_REL) && (phase_in <= i2cram_pkg::PH_NK_LO));
      priority if (!en) begin
         sdal = 1'b1;
      end else if ((phase_in == i2cram_pkg::PH_WB_SET) || (phase_in == i2cram_pkg::PH_WB_HI) ||
                   (phase_in == i2cram_pkg::PH_WB_LO)) begin
         sdal = tx_shift_in[7];
      end else if ((phase_in == i2cram_pkg::PH_START_B) ||
                   (phase_in == i2cram_pkg::PH_START_C) ||
                   (phase_in == i2cram_pkg::PH_STOP_A)  ||
                   (phase_in == i2cram_pkg::PH_STOP_B)) begin
         sdal = 1'b0;
      end else begin
         sdal = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cram_pkg::PH_IDLE;
         bit_index_ff  <= 4'd0;
         tx_shift_ff   <= 8'd0;
         byte_step_ff  <= 3'd0;
         txn_kind_ff   <= 2'd0;
         reg_latch_ff  <= 8'd0;
         data_latch_ff <= 8'd0;
         ack_flag_ff   <= 1'b0;
         rx_byte_ff    <= 8'd0;
         valid_ff      <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff      <= phase_in;
            bit_index_ff  <= bit_index_in;
            tx_shift_ff   <= tx_shift_in;
            byte_step_ff  <= byte_step_in;
            txn_kind_ff   <= txn_kind_in;
            reg_latch_ff  <= reg_latch_in;
            data_latch_ff <= data_latch_in;
            ack_flag_ff   <= ack_flag_in;
            rx_byte_ff    <= rx_byte_in;
            valid_ff      <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         scl_ff  <= scl;
         sdal_ff <= sdal;
         en_ff   <= en;
         busy_ff <= (phase_in != i2cram_pkg::PH_IDLE);
         done_ff <= done;
         ack_ff  <= ack_flag_in;
         rd_ff   <= rx_byte_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_scl_level  = scl_ff;
   assign rsp_sda_level  = sdal_ff;
   assign rsp_sda_enable = en_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_done_res   = done_ff;
   assign rsp_ack_ok     = ack_ff;
   assign rsp_rd_data    = rd_ff;

endmodule
